/* rtl/tksd_pkg.sv */
package tksd_pkg;

  localparam int MAX_SEQ_BYTES = 32;
  localparam int DEF_NUM_MODIFIERS = 8;
  localparam int CNT_W = $clog2(MAX_SEQ_BYTES + 1);
  localparam int LEN_W = 6;
  localparam int NUM_W = 31;
  localparam int TICK_W = 16;
  localparam int ADDR_W = 3;

  localparam logic [NUM_W-1:0] NUM_MAX = '1;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd100;

  localparam logic [7:0] ESC_BYTE = 8'h1B;
  localparam logic [7:0] MOD_SHIFT = 8'h01;
  localparam logic [7:0] MOD_ALT = 8'h02;
  localparam logic [7:0] MOD_CTRL = 8'h04;

  // register index, decoded from paddr[2]
  localparam logic REG_ESC_TIMEOUT = 1'b0;
  localparam logic REG_UTF8_TIMEOUT = 1'b1;

  // dense function key numbers
  localparam logic [4:0] FK_UP = 5'd0;
  localparam logic [4:0] FK_DOWN = 5'd1;
  localparam logic [4:0] FK_RIGHT = 5'd2;
  localparam logic [4:0] FK_LEFT = 5'd3;
  localparam logic [4:0] FK_END = 5'd4;
  localparam logic [4:0] FK_HOME = 5'd5;
  localparam logic [4:0] FK_F1 = 5'd6;
  localparam logic [4:0] FK_F2 = 5'd7;
  localparam logic [4:0] FK_F3 = 5'd8;
  localparam logic [4:0] FK_F4 = 5'd9;
  localparam logic [4:0] FK_INSERT = 5'd10;
  localparam logic [4:0] FK_DELETE = 5'd11;
  localparam logic [4:0] FK_PGUP = 5'd12;
  localparam logic [4:0] FK_PGDN = 5'd13;
  localparam logic [4:0] FK_F5 = 5'd14;
  localparam logic [4:0] FK_F6 = 5'd15;
  localparam logic [4:0] FK_F7 = 5'd16;
  localparam logic [4:0] FK_F8 = 5'd17;
  localparam logic [4:0] FK_F9 = 5'd18;
  localparam logic [4:0] FK_F10 = 5'd19;
  localparam logic [4:0] FK_F11 = 5'd20;
  localparam logic [4:0] FK_F12 = 5'd21;
  localparam logic [4:0] FK_MENU = 5'd22;
  localparam logic [4:0] FK_BRSTART = 5'd23;
  localparam logic [4:0] FK_TAB = 5'd24;
  localparam logic [4:0] FK_ENTER = 5'd25;
  localparam logic [4:0] FK_ESCAPE = 5'd26;
  localparam logic [4:0] FK_BACKSPACE = 5'd27;
  localparam logic [4:0] FK_SCRLK = 5'd28;
  localparam logic [4:0] FK_PRTSC = 5'd29;
  localparam logic [4:0] FK_PAUSE = 5'd30;
  localparam logic [4:0] FK_NONE = 5'd31;

  typedef enum logic [2:0] {
    PH_IDLE, PH_UTF8, PH_ESC, PH_CSI_PARAM, PH_CSI_INTER, PH_SS3, PH_ESC2, PH_ESC2_BR
  } phase_t;

  typedef enum logic [2:0] {
    ST_MAIN, ST_COLON1, ST_ALT, ST_BASE, ST_MOD, ST_EVENT
  } stage_t;

  typedef struct packed {
    stage_t           stage;
    logic             perr;
    logic             digits;
    logic             alt_present;
    logic [NUM_W-1:0] main_num;
    logic [NUM_W-1:0] alt_num;
    logic [NUM_W-1:0] mod_num;
    logic [NUM_W-1:0] scratch;
  } field_t;

  localparam field_t FIELD_RESET = '{
    stage: ST_MAIN, perr: 1'b0, digits: 1'b0, alt_present: 1'b0,
    main_num: 31'd1, alt_num: '0, mod_num: '0, scratch: '0
  };

  typedef struct packed {
    logic             event_valid;
    logic             is_function_key;
    logic [4:0]       function_key;
    logic [NUM_W-1:0] code_point;
    logic [7:0]       modifier_bits;
  } key_t;

  function automatic logic is_ctrl(logic [7:0] c);
    return (c < 8'd32) || (c == 8'd127);
  endfunction

  function automatic logic is_upper(logic [7:0] c);
    return (c >= "A") && (c <= "Z");
  endfunction

  function automatic logic [7:0] paste_byte(logic [1:0] k);
    logic [7:0] r;
    unique case (k)
      2'd0: r = "2";
      2'd1, 2'd2: r = "0";
      default: r = "~";
    endcase
    return r;
  endfunction

  function automatic logic [4:0] letter_key(logic [7:0] c);
    logic [4:0] r;
    unique case (c)
      "A": r = FK_UP;
      "B": r = FK_DOWN;
      "C": r = FK_RIGHT;
      "D": r = FK_LEFT;
      "F": r = FK_END;
      "H": r = FK_HOME;
      "P": r = FK_F1;
      "Q": r = FK_F2;
      "R": r = FK_F3;
      "S": r = FK_F4;
      default: r = FK_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] tilde_key(logic [NUM_W-1:0] n);
    logic [4:0] r;
    unique case (n)
      31'd1, 31'd7: r = FK_HOME;
      31'd2: r = FK_INSERT;
      31'd3: r = FK_DELETE;
      31'd4, 31'd8: r = FK_END;
      31'd5: r = FK_PGUP;
      31'd6: r = FK_PGDN;
      31'd11: r = FK_F1;
      31'd12: r = FK_F2;
      31'd13: r = FK_F3;
      31'd14: r = FK_F4;
      31'd15: r = FK_F5;
      31'd17: r = FK_F6;
      31'd18: r = FK_F7;
      31'd19: r = FK_F8;
      31'd20: r = FK_F9;
      31'd21: r = FK_F10;
      31'd23: r = FK_F11;
      31'd24: r = FK_F12;
      31'd29: r = FK_MENU;
      31'd200: r = FK_BRSTART;
      default: r = FK_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] u_key(logic [NUM_W-1:0] n);
    logic [4:0] r;
    unique case (n)
      31'd9: r = FK_TAB;
      31'd13: r = FK_ENTER;
      31'd27: r = FK_ESCAPE;
      31'd127: r = FK_BACKSPACE;
      31'd57359: r = FK_SCRLK;
      31'd57361: r = FK_PRTSC;
      31'd57362: r = FK_PAUSE;
      31'd57363: r = FK_MENU;
      default: r = FK_NONE;
    endcase
    return r;
  endfunction

endpackage

/* rtl/tksd_if.sv */
interface tksd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  modport source(output valid, req_type, data_byte, input ready);
  modport sink(input valid, req_type, data_byte, output ready);
endinterface

interface tksd_out_if;
  logic        valid;
  logic        ready;
  logic        event_valid;
  logic        is_function_key;
  logic [4:0]  function_key;
  logic [30:0] code_point;
  logic [7:0]  modifier_bits;
  logic [5:0]  sequence_length;
  modport source(output valid, event_valid, is_function_key, function_key, code_point,
                 modifier_bits, sequence_length, input ready);
  modport sink(input valid, event_valid, is_function_key, function_key, code_point,
               modifier_bits, sequence_length, output ready);
endinterface

/* rtl/tksd_field.sv */
// CSI parameter parser: one body byte folded into the field state.
module tksd_field #(
  parameter int NUM_MODIFIERS = tksd_pkg::DEF_NUM_MODIFIERS
) (
  input  tksd_pkg::field_t cur,
  input  logic [7:0]       c,
  output tksd_pkg::field_t nxt
);

  localparam logic [tksd_pkg::NUM_W-1:0] MOD_LIMIT = tksd_pkg::NUM_W'(1) << NUM_MODIFIERS;

  logic                      dig;
  logic [tksd_pkg::NUM_W-1:0] op;
  logic [tksd_pkg::NUM_W+3:0] sum;
  logic                      ovf;
  logic [tksd_pkg::NUM_W-1:0] accv;

  assign dig = (c >= "0") && (c <= "9");

  // shared decimal accumulator
  always_comb begin
    unique case (cur.stage)
      tksd_pkg::ST_MAIN:   op = cur.digits ? cur.main_num : '0;
      tksd_pkg::ST_ALT:    op = cur.alt_num;
      tksd_pkg::ST_MOD:    op = cur.mod_num;
      tksd_pkg::ST_BASE,
      tksd_pkg::ST_EVENT:  op = cur.scratch;
      default:             op = '0;
    endcase
  end

  assign sum  = (tksd_pkg::NUM_W+4)'(op) * (tksd_pkg::NUM_W+4)'(10)
              + (tksd_pkg::NUM_W+4)'(c[3:0]);
  assign ovf  = sum > (tksd_pkg::NUM_W+4)'(tksd_pkg::NUM_MAX);
  assign accv = ovf ? tksd_pkg::NUM_MAX : sum[tksd_pkg::NUM_W-1:0];

  always_comb begin
    nxt = cur;
    if (!cur.perr) begin
      unique case (cur.stage)
        tksd_pkg::ST_MAIN: begin
          if (dig) begin
            nxt.main_num = accv;
            nxt.digits = 1'b1;
            nxt.perr = ovf;
          end else if (c == ":") begin
            nxt.stage = tksd_pkg::ST_COLON1;
          end else if (c == ";") begin
            nxt.stage = tksd_pkg::ST_MOD;
          end else begin
            nxt.perr = 1'b1;
          end
        end
        tksd_pkg::ST_COLON1: begin
          if (dig) begin
            nxt.alt_num = accv;
            nxt.alt_present = 1'b1;
            nxt.stage = tksd_pkg::ST_ALT;
          end else if (c == ":") begin
            nxt.scratch = '0;
            nxt.digits = 1'b0;
            nxt.stage = tksd_pkg::ST_BASE;
          end else begin
            nxt.perr = 1'b1;
          end
        end
        tksd_pkg::ST_ALT: begin
          if (dig) begin
            nxt.alt_num = accv;
            nxt.perr = ovf;
          end else if (c == ":") begin
            nxt.scratch = '0;
            nxt.digits = 1'b0;
            nxt.stage = tksd_pkg::ST_BASE;
          end else if (c == ";") begin
            nxt.stage = tksd_pkg::ST_MOD;
          end else begin
            nxt.perr = 1'b1;
          end
        end
        tksd_pkg::ST_BASE: begin
          if (dig) begin
            nxt.scratch = accv;
            nxt.digits = 1'b1;
            nxt.perr = ovf;
          end else if (c == ";" && cur.digits) begin
            nxt.stage = tksd_pkg::ST_MOD;
          end else begin
            nxt.perr = 1'b1;
          end
        end
        tksd_pkg::ST_MOD: begin
          if (dig) begin
            nxt.mod_num = accv;
            nxt.perr = ovf;
          end else if (c == ":" && cur.mod_num <= MOD_LIMIT) begin
            nxt.scratch = '0;
            nxt.digits = 1'b0;
            nxt.stage = tksd_pkg::ST_EVENT;
          end else begin
            nxt.perr = 1'b1;
          end
        end
        default: begin
          if (dig) begin
            nxt.scratch = accv;
            nxt.digits = 1'b1;
            nxt.perr = ovf;
          end else begin
            nxt.perr = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

/* rtl/tksd_decode.sv */
// Maps a framed sequence to a key event.
module tksd_decode #(
  parameter int NUM_MODIFIERS = tksd_pkg::DEF_NUM_MODIFIERS
) (
  input  logic [tksd_pkg::CNT_W-1:0] cnt,
  input  logic [3:0][7:0]            head,
  input  logic [7:0]                 fin,
  input  tksd_pkg::field_t           fld,
  input  logic                       paste,
  output tksd_pkg::key_t             key
);

  localparam logic [tksd_pkg::NUM_W-1:0] MOD_LIMIT = tksd_pkg::NUM_W'(1) << NUM_MODIFIERS;

  logic                       body_ok;
  logic [7:0]                 mods;
  logic [4:0]                 uk, tk, lk, ssk;
  logic [7:0]                 ch, c0;
  logic [tksd_pkg::NUM_W-1:0] num;

  always_comb begin
    unique case (fld.stage)
      tksd_pkg::ST_MAIN, tksd_pkg::ST_ALT: body_ok = 1'b1;
      tksd_pkg::ST_COLON1:                 body_ok = 1'b0;
      tksd_pkg::ST_BASE:                   body_ok = fld.digits;
      tksd_pkg::ST_MOD:                    body_ok = fld.mod_num <= MOD_LIMIT;
      default: body_ok = fld.digits && (fld.scratch == tksd_pkg::NUM_W'(1));
    endcase
    body_ok = body_ok && !fld.perr;
  end

  assign mods = (fld.mod_num != '0) ? 8'(fld.mod_num - tksd_pkg::NUM_W'(1)) : 8'h00;
  assign uk   = tksd_pkg::u_key(fld.main_num);
  assign tk   = tksd_pkg::tilde_key(fld.main_num);
  assign lk   = tksd_pkg::letter_key(fin);
  assign ssk  = tksd_pkg::letter_key(head[2]);

  // control byte folded to its letter, lower case
  always_comb begin
    c0 = head[0] ^ 8'h40;
    if (tksd_pkg::is_upper(c0)) c0 = c0 + 8'd32;
    ch = head[1] ^ 8'h40;
    if (tksd_pkg::is_upper(ch)) ch = ch + 8'd32;
  end

  always_comb begin
    key = '0;
    num = fld.main_num;
    if (tksd_pkg::is_ctrl(head[0])) begin
      if (cnt == tksd_pkg::CNT_W'(1)) begin
        key.event_valid = 1'b1;
        key.code_point = tksd_pkg::NUM_W'(c0);
        key.modifier_bits = tksd_pkg::MOD_CTRL;
      end else if (head[0] == tksd_pkg::ESC_BYTE) begin
        if (cnt == tksd_pkg::CNT_W'(2)) begin
          if (head[1] <= 8'd127) begin
            key.event_valid = 1'b1;
            if (tksd_pkg::is_ctrl(head[1])) begin
              key.code_point = tksd_pkg::NUM_W'(ch);
              key.modifier_bits = tksd_pkg::MOD_ALT | tksd_pkg::MOD_CTRL;
            end else if (tksd_pkg::is_upper(head[1])) begin
              key.code_point = tksd_pkg::NUM_W'(head[1] + 8'd32);
              key.modifier_bits = tksd_pkg::MOD_ALT | tksd_pkg::MOD_SHIFT;
            end else begin
              key.code_point = tksd_pkg::NUM_W'(head[1]);
              key.modifier_bits = tksd_pkg::MOD_ALT;
            end
          end
        end else if (cnt == tksd_pkg::CNT_W'(3) && head[1] == "O") begin
          if (ssk != tksd_pkg::FK_NONE) begin
            key.event_valid = 1'b1;
            key.is_function_key = 1'b1;
            key.function_key = ssk;
          end
        end else if (head[1] == "[") begin
          if (body_ok) begin
            if (fin == "Z") begin
              if (num == tksd_pkg::NUM_W'(1)) begin
                key.event_valid = 1'b1;
                key.is_function_key = 1'b1;
                key.function_key = tksd_pkg::FK_TAB;
                key.modifier_bits = mods | tksd_pkg::MOD_SHIFT;
              end
            end else if (fin == "u") begin
              if (uk != tksd_pkg::FK_NONE) begin
                key.event_valid = 1'b1;
                key.is_function_key = 1'b1;
                key.function_key = uk;
                key.modifier_bits = mods;
              end else if (num >= 31'd57344 && num <= 31'd63743) begin
                key.event_valid = 1'b0;
              end else if (fld.alt_present && !mods[0]) begin
                key.event_valid = 1'b0;
              end else begin
                key.event_valid = 1'b1;
                key.code_point = num;
                key.modifier_bits = mods;
                if (fld.alt_present && !(num >= 31'd97 && num <= 31'd122)) begin
                  key.code_point = fld.alt_num;
                  key.modifier_bits = mods & ~tksd_pkg::MOD_SHIFT;
                end
              end
            end else if (fin == "~") begin
              if (tk != tksd_pkg::FK_NONE && (tk != tksd_pkg::FK_BRSTART
                  || (paste && cnt == tksd_pkg::CNT_W'(6)))) begin
                key.event_valid = 1'b1;
                key.is_function_key = 1'b1;
                key.function_key = tk;
                key.modifier_bits = mods;
              end
            end else if (lk != tksd_pkg::FK_NONE && fin != "R"
                         && num == tksd_pkg::NUM_W'(1)) begin
              key.event_valid = 1'b1;
              key.is_function_key = 1'b1;
              key.function_key = lk;
              key.modifier_bits = mods;
            end
          end
        end else if (head[1] == tksd_pkg::ESC_BYTE && cnt == tksd_pkg::CNT_W'(4)
                     && head[2] == "[") begin
          if (head[3] >= "A" && head[3] <= "D") begin
            key.event_valid = 1'b1;
            key.is_function_key = 1'b1;
            key.function_key = tksd_pkg::letter_key(head[3]);
            key.modifier_bits = tksd_pkg::MOD_ALT;
          end
        end
      end
    end
  end

endmodule

/* rtl/terminal_key_sequence_decoder.sv */
// Channel  Modport            Beat contents
// rx       tksd_in_if.sink    req_type (0 byte, 1 tick), data_byte
// evt      tksd_out_if.source key event fields, sequence_length
// apb      psel/penable/...   0x0 escape_timeout_ticks, 0x4 utf8_timeout_ticks
//
// One beat per cycle on rx. A beat that ends a sequence (final byte, lone
// byte, completed UTF-8 character or timeout tick) loads the result register,
// which evt drains; rx.ready drops only while that register is full and evt
// is stalled. Parser and decoder are combinational between the sequence state
// and the result register.
// rst (synchronous) clears the sequence state, empties the result register
// and sets both timeouts to 100 ticks.
module terminal_key_sequence_decoder #(
  parameter int NUM_MODIFIERS = tksd_pkg::DEF_NUM_MODIFIERS
) (
  input  logic                        clk,
  input  logic                        rst,
  tksd_in_if.sink                     rx,
  tksd_out_if.source                  evt,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tksd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int CW = tksd_pkg::CNT_W;

  // configuration
  logic [tksd_pkg::TICK_W-1:0] esc_to, utf8_to;

  // sequence state
  tksd_pkg::phase_t            phase, phase_next;
  logic [CW-1:0]               cnt, cnt_next, cnt_add;
  logic [3:0][7:0]             head, head_next, head_add;
  tksd_pkg::field_t            fld, fld_next, fld_fed;
  logic                        paste, paste_next, paste_hit;
  logic [1:0]                  rem, rem_next, rem_dec;
  logic [tksd_pkg::TICK_W-1:0] tick, tick_next, tick_inc;
  logic [7:0]                  last, last_next;

  // result register
  logic                        res_valid;
  tksd_pkg::key_t              res;
  logic [tksd_pkg::LEN_W-1:0]  res_len;

  logic                        accept, finish, is_tick;
  logic [7:0]                  b;
  logic [CW-1:0]               k_idx, dec_cnt;
  logic [3:0][7:0]             dec_head;
  logic [7:0]                  dec_fin;
  logic                        dec_paste;
  tksd_pkg::key_t              key;

  assign pready = 1'b1;
  assign prdata = {16'h0000, (paddr[2] == tksd_pkg::REG_UTF8_TIMEOUT) ? utf8_to : esc_to};

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_to <= tksd_pkg::TIMEOUT_RESET;
      utf8_to <= tksd_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == tksd_pkg::REG_UTF8_TIMEOUT) utf8_to <= pwdata[15:0];
      else esc_to <= pwdata[15:0];
    end
  end

  assign rx.ready = !res_valid || evt.ready;
  assign accept   = rx.valid && rx.ready;
  assign is_tick  = rx.req_type;
  assign b        = rx.data_byte;

  // byte appended: first four kept, length saturates
  always_comb begin
    cnt_add = (cnt < CW'(tksd_pkg::MAX_SEQ_BYTES)) ? cnt + CW'(1) : cnt;
    head_add = head;
    for (int i = 0; i < 4; i++) begin
      if (cnt == CW'(i)) head_add[i] = b;
    end
  end

  // bracketed paste start must be exactly 2 0 0 ~
  assign k_idx     = cnt - CW'(2);
  assign paste_hit = (k_idx < CW'(4)) && (b == tksd_pkg::paste_byte(k_idx[1:0]));
  assign tick_inc  = (tick == '1) ? tick : tick + tksd_pkg::TICK_W'(1);
  assign rem_dec   = (rem != 2'd0) ? rem - 2'd1 : 2'd0;

  // body bytes are folded in as they arrive; the fold of the final byte is
  // discarded because the sequence is cleared on that beat
  tksd_field #(.NUM_MODIFIERS(NUM_MODIFIERS)) u_field (
    .cur(fld),
    .c  (b),
    .nxt(fld_fed)
  );

  assign dec_cnt   = is_tick ? cnt : cnt_add;
  assign dec_head  = is_tick ? head : head_add;
  assign dec_fin   = is_tick ? last : b;
  assign dec_paste = is_tick ? paste : (paste && paste_hit);

  tksd_decode #(.NUM_MODIFIERS(NUM_MODIFIERS)) u_decode (
    .cnt  (dec_cnt),
    .head (dec_head),
    .fin  (dec_fin),
    .fld  (fld),
    .paste(dec_paste),
    .key  (key)
  );

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    head_next  = head;
    fld_next   = fld;
    paste_next = paste;
    rem_next   = rem;
    tick_next  = tick;
    last_next  = last;
    finish     = 1'b0;
    if (accept) begin
      if (is_tick) begin
        unique case (phase)
          tksd_pkg::PH_IDLE: ;
          tksd_pkg::PH_UTF8: begin
            tick_next = tick_inc;
            finish = tick_inc >= utf8_to;
          end
          default: begin
            if (esc_to != '0) begin
              tick_next = tick_inc;
              finish = tick_inc >= esc_to;
            end
          end
        endcase
      end else begin
        tick_next = '0;
        cnt_next  = cnt_add;
        head_next = head_add;
        last_next = b;
        unique case (phase)
          tksd_pkg::PH_IDLE: begin
            if (b >= 8'hC0 && b <= 8'hF7) begin
              rem_next = (b >= 8'hF0) ? 2'd3 : ((b >= 8'hE0) ? 2'd2 : 2'd1);
              phase_next = tksd_pkg::PH_UTF8;
            end else if (b == tksd_pkg::ESC_BYTE) begin
              phase_next = tksd_pkg::PH_ESC;
            end else begin
              finish = 1'b1;
            end
          end
          tksd_pkg::PH_UTF8: begin
            rem_next = rem_dec;
            finish = (rem_dec == 2'd0);
          end
          tksd_pkg::PH_ESC: begin
            if (b == "[") phase_next = tksd_pkg::PH_CSI_PARAM;
            else if (b == "O") phase_next = tksd_pkg::PH_SS3;
            else if (b == tksd_pkg::ESC_BYTE) phase_next = tksd_pkg::PH_ESC2;
            else finish = 1'b1;
          end
          tksd_pkg::PH_CSI_PARAM, tksd_pkg::PH_CSI_INTER: begin
            fld_next = fld_fed;
            paste_next = paste && paste_hit;
            if (phase == tksd_pkg::PH_CSI_PARAM && b >= 8'h30 && b <= 8'h3F) begin
              phase_next = phase;
            end else if (b >= 8'h20 && b <= 8'h2F) begin
              phase_next = tksd_pkg::PH_CSI_INTER;
            end else begin
              finish = 1'b1;
            end
          end
          tksd_pkg::PH_ESC2: begin
            if (b == "[") phase_next = tksd_pkg::PH_ESC2_BR;
            else finish = 1'b1;
          end
          default: finish = 1'b1;
        endcase
      end
    end
    if (finish) begin
      phase_next = tksd_pkg::PH_IDLE;
      cnt_next   = '0;
      head_next  = '0;
      fld_next   = tksd_pkg::FIELD_RESET;
      paste_next = 1'b1;
      rem_next   = 2'd0;
      tick_next  = '0;
      last_next  = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tksd_pkg::PH_IDLE;
      cnt   <= '0;
      head  <= '0;
      fld   <= tksd_pkg::FIELD_RESET;
      paste <= 1'b1;
      rem   <= 2'd0;
      tick  <= '0;
      last  <= 8'h00;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
      head  <= head_next;
      fld   <= fld_next;
      paste <= paste_next;
      rem   <= rem_next;
      tick  <= tick_next;
      last  <= last_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (evt.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res     <= key;
      res_len <= tksd_pkg::LEN_W'(dec_cnt);
    end
  end

  assign evt.valid           = res_valid;
  assign evt.event_valid     = res.event_valid;
  assign evt.is_function_key = res.is_function_key;
  assign evt.function_key    = res.function_key;
  assign evt.code_point      = res.code_point;
  assign evt.modifier_bits   = res.modifier_bits;
  assign evt.sequence_length = res_len;

endmodule
